// ----- hdl/clap_pkg.sv -----
// ----------------------------------------------------------------------------
// clap_pkg: shared definitions for the comment lane allocator
// Register map, kind and status codes, reset values and the walk token type.
// ----------------------------------------------------------------------------
`default_nettype none

package clap_pkg;

    // default number of scrolling row cells
    localparam int unsigned MAX_ROWS_DEF = 64;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FONT_SIZE     = 3'd2;
    localparam logic [2:0] REG_ROW_COUNT     = 3'd3;
    localparam logic [2:0] REG_SCROLL_DUR    = 3'd4;
    localparam logic [2:0] REG_STILL_DUR     = 3'd5;
    localparam logic [2:0] REG_DISALLOW      = 3'd6;

    // register reset values
    localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd1920;
    localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd1080;
    localparam logic [7:0]  RST_FONT_SIZE     = 8'd25;
    localparam logic [6:0]  RST_ROW_COUNT     = 7'd43;
    localparam logic [15:0] RST_SCROLL_DUR    = 16'd5000;
    localparam logic [15:0] RST_STILL_DUR     = 16'd5000;
    localparam logic [2:0]  RST_DISALLOW      = 3'd0;

    // disallow mask bits
    localparam int unsigned DIS_TOP    = 0;
    localparam int unsigned DIS_BOTTOM = 1;
    localparam int unsigned DIS_SCROLL = 2;

    // comment kinds (below KIND_BOTTOM means scrolling)
    localparam logic [2:0] KIND_BOTTOM = 3'd4;
    localparam logic [2:0] KIND_TOP    = 3'd5;

    // longest accepted comment
    localparam logic [7:0] MAX_CHARS = 8'd100;

    // result status codes
    localparam logic [1:0] ST_PLACED   = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_DISALLOW = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    // search token that walks down the row cells
    typedef struct packed {
        logic       valid;
        logic       found;
        logic [7:0] row;
    } t_token;

endpackage

`default_nettype wire

// ----- hdl/clap_div.sv -----
// ----------------------------------------------------------------------------
// clap_div: bit-serial restoring divider
// Divides a 31-bit dividend by a 15-bit divisor, one quotient bit a cycle.
// The quotient is known to fit 16 bits, so 16 steps are enough.
// ----------------------------------------------------------------------------
`default_nettype none

module clap_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [30:0] i_dividend,
    input  wire logic [14:0] i_divisor,
    output logic             o_done,
    output logic [15:0]      o_quotient
);

    logic [14:0] r_rem;
    logic [15:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [15:0] shifted;
    logic [16:0] diff;
    logic        ge;

    // one trial subtraction per cycle
    assign shifted = {r_rem, r_quo[15]};
    assign diff    = {1'b0, shifted} - {2'b00, i_divisor};
    assign ge      = ~diff[16];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, dividend low bits shift out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[30:16];
            r_quo <= i_dividend[15:0];
        end else if (r_busy) begin
            r_rem <= ge ? diff[14:0] : shifted[14:0];
            r_quo <= {r_quo[14:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- hdl/clap_row_cell.sv -----
// ----------------------------------------------------------------------------
// clap_row_cell: one scrolling row
// Holds the row's free and clear times and checks the passing search token.
// The first free enabled row claims the comment and marks the token found.
// ----------------------------------------------------------------------------
`default_nettype none

module clap_row_cell #(
    parameter int unsigned CELL_IDX = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire clap_pkg::t_token i_tok,
    output clap_pkg::t_token      o_tok,
    input  wire logic [32:0]     i_border,
    input  wire logic [31:0]     i_time,
    input  wire logic [31:0]     i_free_new,
    input  wire logic [31:0]     i_clear_new,
    input  wire logic [6:0]      i_row_count
);

    localparam logic [7:0] IDX = 8'(CELL_IDX);

    logic [31:0]      r_free;
    logic [31:0]      r_clear;
    clap_pkg::t_token r_tok;

    logic en;
    logic hit;

    // row is searched only below the configured row count
    assign en  = IDX < {1'b0, i_row_count};
    assign hit = i_tok.valid && !i_tok.found && en
                 && (i_border > {1'b0, r_free}) && (i_time > r_clear);

    // row times
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free  <= '0;
            r_clear <= '0;
        end else if (hit) begin
            r_free  <= i_free_new;
            r_clear <= i_clear_new;
        end
    end

    // token handed to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok.valid <= i_tok.valid;
            r_tok.found <= i_tok.found | hit;
            r_tok.row   <= hit ? IDX : i_tok.row;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ----- hdl/comment_lane_allocator.sv -----
// ----------------------------------------------------------------------------
// comment_lane_allocator: places overlay comments on screen rows
// Scrolling comments search a chain of row cells; top and bottom comments
// stack on counters that restart after the still duration.
//
// channel   direction  handshake            payload
// s_axis    in         tvalid/tready        tdata: appear_ms, char_count
//                                           tuser: comment_kind
// m_axis    out        tvalid/tready        tdata: row_index, y_pos, text_width
//                                           tuser: status
// apb       in/out     psel/penable/pready  7 registers at 4*i
//
// A scrolling comment goes from one accept to the next through check, divider
// start, divider, the search token's pass down the row cells, position, result
// load and the accepting idle. Top and bottom comments skip the divider and the
// search; rejected and disallowed ones go from check to result load. One comment
// is in work at a time; the result register lets the next comment in while a
// result waits. Synchronous reset restores all row times, stacks and config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module comment_lane_allocator #(
    parameter int unsigned MAX_ROWS = clap_pkg::MAX_ROWS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input requests
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // appear_ms[31:0], char_count[39:32]
    input  wire logic [2:0]  s_axis_tuser,   // comment_kind[2:0]
    // results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // row_index[7:0], y_pos[19:8],
                                             // text_width[34:20], zero[39:35]
    output logic [1:0]       m_axis_tuser,   // status[1:0]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // state codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHK    = 3'd1;
    localparam logic [2:0] S_DSTART = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_YMUL   = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    // configuration registers
    logic [11:0] r_width;
    logic [11:0] r_height;
    logic [7:0]  r_font;
    logic [6:0]  r_row_count;
    logic [15:0] r_scroll;
    logic [15:0] r_still;
    logic [2:0]  r_disallow;

    // request in work
    logic [2:0]  r_state;
    logic [31:0] r_time;
    logic [2:0]  r_kind;
    logic        r_reject;
    logic [14:0] r_tw;
    logic [1:0]  r_status;
    logic [7:0]  r_row;
    logic [15:0] r_off;
    logic [30:0] r_prod;
    logic [14:0] r_den;
    logic [32:0] r_border;
    logic [31:0] r_free_new;
    logic [31:0] r_clear_new;
    logic        r_launch;

    // stack state
    logic [31:0] r_top_grp;
    logic [31:0] r_bot_grp;
    logic [8:0]  r_top_row;
    logic [8:0]  r_bot_row;

    // result register
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [7:0]  r_out_row;
    logic [11:0] r_out_y;
    logic [14:0] r_out_tw;

    logic        in_acc;
    logic        cfg_wr;
    logic [15:0] chars_prod;
    logic        is_bottom;
    logic [31:0] sel_grp;
    logic [8:0]  sel_row;
    logic [32:0] ago;
    logic        restart;
    logic [8:0]  n_stack_row;
    logic [14:0] twp;
    logic        div_done;
    logic [15:0] div_quo;
    logic [32:0] t_plus_d;
    logic [32:0] t_plus_a;
    logic [11:0] y_val;
    logic        out_free;

    clap_pkg::t_token tok [MAX_ROWS+1];

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_out_valid || m_axis_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= clap_pkg::RST_SCREEN_WIDTH;
            r_height    <= clap_pkg::RST_SCREEN_HEIGHT;
            r_font      <= clap_pkg::RST_FONT_SIZE;
            r_row_count <= clap_pkg::RST_ROW_COUNT;
            r_scroll    <= clap_pkg::RST_SCROLL_DUR;
            r_still     <= clap_pkg::RST_STILL_DUR;
            r_disallow  <= clap_pkg::RST_DISALLOW;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                clap_pkg::REG_SCREEN_WIDTH:  r_width     <= pwdata[11:0];
                clap_pkg::REG_SCREEN_HEIGHT: r_height    <= pwdata[11:0];
                clap_pkg::REG_FONT_SIZE:     r_font      <= pwdata[7:0];
                clap_pkg::REG_ROW_COUNT:     r_row_count <= pwdata[6:0];
                clap_pkg::REG_SCROLL_DUR:    r_scroll    <= pwdata[15:0];
                clap_pkg::REG_STILL_DUR:     r_still     <= pwdata[15:0];
                clap_pkg::REG_DISALLOW:      r_disallow  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[4:2])
            clap_pkg::REG_SCREEN_WIDTH:  prdata = {20'd0, r_width};
            clap_pkg::REG_SCREEN_HEIGHT: prdata = {20'd0, r_height};
            clap_pkg::REG_FONT_SIZE:     prdata = {24'd0, r_font};
            clap_pkg::REG_ROW_COUNT:     prdata = {25'd0, r_row_count};
            clap_pkg::REG_SCROLL_DUR:    prdata = {16'd0, r_scroll};
            clap_pkg::REG_STILL_DUR:     prdata = {16'd0, r_still};
            clap_pkg::REG_DISALLOW:      prdata = {29'd0, r_disallow};
            default:                     prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // text width at accept
    assign chars_prod = s_axis_tdata[39:32] * r_font;

    // stack step for the selected side
    assign is_bottom = (r_kind == clap_pkg::KIND_BOTTOM);
    assign sel_grp   = is_bottom ? r_bot_grp : r_top_grp;
    assign sel_row   = is_bottom ? r_bot_row : r_top_row;
    assign ago       = {1'b0, r_time} - {1'b0, sel_grp};
    assign restart   = $signed(ago) > $signed({17'd0, r_still});
    always_comb begin
        if (restart) begin
            n_stack_row = '0;
        end else if (sel_row[8] || (sel_row[7:0] != 8'hFF)) begin
            n_stack_row = sel_row + 9'd1;
        end else begin
            n_stack_row = sel_row;
        end
    end

    // scrolling width plus margin
    assign twp = r_tw + 15'd2;

    // visible time divider
    clap_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DSTART),
        .i_dividend (r_prod),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign t_plus_d = {1'b0, r_time} + {17'd0, r_scroll};
    assign t_plus_a = {1'b0, r_time} + {17'd0, div_quo};

    // row cell chain
    assign tok[0] = '{valid: r_launch, found: 1'b0, row: 8'd0};

    for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
        clap_row_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (tok[g]),
            .o_tok       (tok[g+1]),
            .i_border    (r_border),
            .i_time      (r_time),
            .i_free_new  (r_free_new),
            .i_clear_new (r_clear_new),
            .i_row_count (r_row_count)
        );
    end

    // vertical position from the row offset
    always_comb begin
        if (r_status != clap_pkg::ST_PLACED) begin
            y_val = '0;
        end else if (is_bottom) begin
            y_val = (r_off >= {4'd0, r_height}) ? 12'd0 : r_height - r_off[11:0];
        end else begin
            y_val = (r_off[15:12] != 4'd0) ? 12'hFFF : r_off[11:0];
        end
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_top_grp   <= '0;
            r_bot_grp   <= '0;
            r_top_row   <= '1;
            r_bot_row   <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_reject) begin
                        r_state <= S_FIN;
                    end else if (!r_kind[2]) begin
                        r_state <= r_disallow[clap_pkg::DIS_SCROLL] ? S_FIN : S_DSTART;
                    end else if (is_bottom) begin
                        if (r_disallow[clap_pkg::DIS_BOTTOM]) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state   <= S_YMUL;
                            r_bot_row <= n_stack_row;
                            if (restart) begin
                                r_bot_grp <= r_time;
                            end
                        end
                    end else begin
                        if (r_disallow[clap_pkg::DIS_TOP]) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state   <= S_YMUL;
                            r_top_row <= n_stack_row;
                            if (restart) begin
                                r_top_grp <= r_time;
                            end
                        end
                    end
                end
                S_DSTART: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state  <= S_WALK;
                        r_launch <= 1'b1;
                    end
                end
                S_WALK: begin
                    if (tok[MAX_ROWS].valid) begin
                        r_state <= S_YMUL;
                    end
                end
                S_YMUL: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // request datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_time   <= s_axis_tdata[31:0];
            r_kind   <= s_axis_tuser;
            r_reject <= (s_axis_tdata[39:32] > clap_pkg::MAX_CHARS)
                        || (s_axis_tuser > clap_pkg::KIND_TOP);
            r_tw     <= chars_prod[14:0];
        end
        case (r_state)
            S_CHK: begin
                r_row  <= '0;
                r_prod <= 31'(twp * r_scroll);
                r_den  <= twp + {3'd0, r_width};
                if (r_reject) begin
                    r_status <= clap_pkg::ST_REJECTED;
                    r_tw     <= '0;
                end else if (!r_kind[2]) begin
                    r_status <= r_disallow[clap_pkg::DIS_SCROLL]
                                ? clap_pkg::ST_DISALLOW : clap_pkg::ST_DROPPED;
                end else if ((is_bottom && r_disallow[clap_pkg::DIS_BOTTOM])
                             || (!is_bottom && r_disallow[clap_pkg::DIS_TOP])) begin
                    r_status <= clap_pkg::ST_DISALLOW;
                end else begin
                    r_status <= clap_pkg::ST_PLACED;
                    r_row    <= n_stack_row[7:0];
                end
            end
            S_DIV: begin
                r_border    <= t_plus_d - {17'd0, div_quo};
                r_free_new  <= t_plus_d[32] ? 32'hFFFF_FFFF : t_plus_d[31:0];
                r_clear_new <= t_plus_a[32] ? 32'hFFFF_FFFF : t_plus_a[31:0];
            end
            S_WALK: begin
                if (tok[MAX_ROWS].valid && tok[MAX_ROWS].found) begin
                    r_status <= clap_pkg::ST_PLACED;
                    r_row    <= tok[MAX_ROWS].row;
                end
            end
            S_YMUL: begin
                r_off <= r_row * r_font;
            end
            default: ;
        endcase
    end

    // result register load
    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_out_status <= r_status;
            r_out_row    <= r_row;
            r_out_y      <= y_val;
            r_out_tw     <= r_tw;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_tw, r_out_y, r_out_row};
    assign m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire
